// File: hw/rtl/tfhc_pkg.sv
// ----------------------------------------------------------------------------
// tfhc_pkg
// Types, constants and the CRC-32 word update shared by the frame header
// generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfhc_pkg;

    localparam int unsigned DIM_W      = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned HDR_BYTES  = 28;
    localparam int unsigned BYTE_IDX_W = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd32;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd24;

    localparam logic [7:0]  MAGIC_0      = 8'h43;
    localparam logic [7:0]  MAGIC_1      = 8'h47;
    localparam logic [7:0]  MAGIC_2      = 8'h54;
    localparam logic [7:0]  MAGIC_3      = 8'h48;
    localparam logic [7:0]  HDR_VERSION  = 8'd1;
    localparam logic [7:0]  FRAME_TYPE   = 8'd1;
    localparam logic [15:0] HDR_LENGTH   = 16'd28;

    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = 5'(HDR_BYTES - 1);

    typedef struct packed {
        logic [31:0]        seq;
        logic [31:0]        stamp;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [2*DIM_W-1:0] area;
        logic [31:0]        crc;
    } t_hdr;

    // Folds a 32-bit word into a reflected CRC register, low byte first.
    function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                               input logic [31:0] data);
        logic [31:0] c;
        c = crc ^ data;
        for (int k = 0; k < 32; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tfhc_front.sv
// ----------------------------------------------------------------------------
// tfhc_front
// Accepts pixel beats, runs the CRC, keeps the frame sequence and the
// configuration registers, and builds one header record per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tfhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tfhc_pkg::DIM_W-1:0]      i_cfg_data,
    input  wire logic                            i_valid,
    input  wire logic [31:0]                     i_pixel_word,
    input  wire logic [31:0]                     i_frame_time_ms,
    input  wire logic                            i_last_pixel,
    input  wire logic                            i_q_full,
    output logic                                 o_ready,
    output logic                                 o_push,
    output tfhc_pkg::t_hdr                       o_hdr
);

    logic [31:0]                 r_crc, n_crc;
    logic [31:0]                 r_seq, n_seq;
    logic [tfhc_pkg::DIM_W-1:0]  r_width, r_height;
    logic [31:0]                 crc_next;
    logic                        accept;

    assign o_ready  = ~i_q_full;
    assign accept   = i_valid & ~i_q_full;
    assign crc_next = tfhc_pkg::crc32_word(r_crc, i_pixel_word);
    assign o_push   = accept & i_last_pixel;

    always_comb begin
        o_hdr.seq    = r_seq;
        o_hdr.stamp  = i_frame_time_ms;
        o_hdr.width  = r_width;
        o_hdr.height = r_height;
        o_hdr.area   = (2*tfhc_pkg::DIM_W)'(r_width) * (2*tfhc_pkg::DIM_W)'(r_height);
        o_hdr.crc    = ~crc_next;
    end

    always_comb begin
        n_crc = r_crc;
        n_seq = r_seq;
        if (accept) begin
            n_crc = i_last_pixel ? tfhc_pkg::CRC_INIT : crc_next;
            if (i_last_pixel) begin
                n_seq = r_seq + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= tfhc_pkg::CRC_INIT;
            r_seq    <= '0;
            r_width  <= tfhc_pkg::WIDTH_RESET;
            r_height <= tfhc_pkg::HEIGHT_RESET;
        end else begin
            r_crc <= n_crc;
            r_seq <= n_seq;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tfhc_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    tfhc_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tfhc_queue.sv
// ----------------------------------------------------------------------------
// tfhc_queue
// Short first-in first-out queue of header records between the pixel side
// and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire tfhc_pkg::t_hdr i_hdr,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_valid,
    output tfhc_pkg::t_hdr o_hdr
);

    localparam int unsigned PTR_W = $clog2(tfhc_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(tfhc_pkg::QUEUE_DEPTH + 1);

    tfhc_pkg::t_hdr    r_mem [tfhc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(tfhc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_hdr   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(tfhc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(tfhc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tfhc_back.sv
// ----------------------------------------------------------------------------
// tfhc_back
// Serializes the header record at the head of the queue into 28 bytes,
// little-endian, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_back (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire tfhc_pkg::t_hdr i_hdr,
    output logic         o_pop,
    output logic         o_valid,
    output logic [7:0]   o_byte,
    output logic         o_last,
    input  wire logic    i_ready
);

    logic [tfhc_pkg::BYTE_IDX_W-1:0] r_idx, n_idx;
    logic                            r_valid;
    logic [7:0]                      r_byte;
    logic                            r_last;
    logic [8*tfhc_pkg::HDR_BYTES-1:0] hdr_vec;
    logic [31:0]                     plen;
    logic                            load;
    logic                            at_end;

    assign plen   = {10'd0, i_hdr.area, 2'b00};
    assign hdr_vec = {i_hdr.crc, plen,
                      {6'd0, i_hdr.height}, {6'd0, i_hdr.width},
                      i_hdr.stamp, i_hdr.seq, tfhc_pkg::HDR_LENGTH,
                      tfhc_pkg::FRAME_TYPE, tfhc_pkg::HDR_VERSION,
                      tfhc_pkg::MAGIC_3, tfhc_pkg::MAGIC_2,
                      tfhc_pkg::MAGIC_1, tfhc_pkg::MAGIC_0};

    assign load   = i_q_valid & (~r_valid | i_ready);
    assign at_end = (r_idx == tfhc_pkg::LAST_BYTE_IDX);
    assign o_pop  = load & at_end;
    assign n_idx  = at_end ? '0 : r_idx + 1'b1;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= hdr_vec[{r_idx, 3'b000} +: 8];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/thermal_frame_header_crc32.sv
// ----------------------------------------------------------------------------
// thermal_frame_header_crc32
// Thermal frame header generator with a running reflected CRC-32.
// ----------------------------------------------------------------------------
// Pixel beats are taken one per clock cycle while the header queue is not full; the
// 32-bit CRC update for each word is combinational. A beat with tlast set closes the
// frame and places a header record in a two-entry queue, so up to two frames may wait
// for output. The serializer sends each header as 28 byte beats, one per cycle while
// the output is ready, and that output rate sets how closely frame ends may follow
// each other before the input side stalls. No clearing pass is needed after reset.
`default_nettype none

module thermal_frame_header_crc32 (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tfhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tfhc_pkg::DIM_W-1:0]      i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [63:0]                     s_axis_tdata,  // pixel_word, frame_time_ms
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // header_byte
    output logic                                 m_axis_tlast
);

    logic           q_full, q_valid, push, pop;
    tfhc_pkg::t_hdr hdr_in, hdr_out;

    tfhc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (s_axis_tvalid),
        .i_pixel_word    (s_axis_tdata[31:0]),
        .i_frame_time_ms (s_axis_tdata[63:32]),
        .i_last_pixel    (s_axis_tlast),
        .i_q_full        (q_full),
        .o_ready         (s_axis_tready),
        .o_push          (push),
        .o_hdr           (hdr_in)
    );

    tfhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_hdr   (hdr_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_hdr   (hdr_out)
    );

    tfhc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_hdr     (hdr_out),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .i_ready   (m_axis_tready)
    );

endmodule

`default_nettype wire

// File: tb/thermal_frame_header_crc32_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_frame_header_crc32_test
// Self-checking bench for the thermal frame header generator.
// ----------------------------------------------------------------------------
// Pixel beats are streamed into the block and a scoreboard folds every
// accepted beat into its own CRC-32. When a frame closes, it queues the 28
// header bytes it expects. Every header beat that leaves the block is checked
// in order against that queue. A directed opening covers the dimension
// extremes, zero dimensions, unmapped register indexes, a change between the
// pixels of one frame and back-to-back frames. Random frames then run under
// three handshake idling mixes, with a long output stall that backs up the
// input.
// ----------------------------------------------------------------------------
module thermal_frame_header_crc32_test;

    typedef logic [tfhc_pkg::DIM_W-1:0]     t_dim;
    typedef logic [tfhc_pkg::CFG_IDX_W-1:0] t_cfg_idx;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 100000;
    localparam int PHASE_ITEMS    = 35;
    localparam t_cfg_idx REG_UNMAPPED_2 = 2'd2;
    localparam t_cfg_idx REG_UNMAPPED_3 = 2'd3;

    typedef struct {
        logic [7:0] value;
        logic       is_end;
        int         offset;
    } t_hdr_beat;

    class header_scoreboard;
        logic [31:0]      crc_acc;
        logic [31:0]      frame_seq;
        t_dim             width_reg;
        t_dim             height_reg;
        t_hdr_beat        beats_due[$];
        int               errors;
        int               pixels_seen;
        int               frames_closed;
        int               bytes_checked;

        function new();
            crc_acc       = tfhc_pkg::CRC_INIT;
            frame_seq     = '0;
            width_reg     = tfhc_pkg::WIDTH_RESET;
            height_reg    = tfhc_pkg::HEIGHT_RESET;
            errors        = 0;
            pixels_seen   = 0;
            frames_closed = 0;
            bytes_checked = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_dim data);
            if (idx == tfhc_pkg::REG_FRAME_WIDTH) begin
                width_reg = data;
            end else if (idx == tfhc_pkg::REG_FRAME_HEIGHT) begin
                height_reg = data;
            end
        endfunction

        function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
            c = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ tfhc_pkg::CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void note_pixel(logic [31:0] word, logic last, logic [31:0] stamp);
            logic [7:0]  hdr [tfhc_pkg::HDR_BYTES];
            logic [31:0] payload;
            t_hdr_beat   beat;
            pixels_seen++;
            for (int b = 0; b < 4; b++) begin
                crc_acc = fold_byte(crc_acc, word[8*b +: 8]);
            end
            if (!last) begin
                return;
            end
            payload = 32'(width_reg) * 32'(height_reg) * 32'd4;
            hdr[0] = tfhc_pkg::MAGIC_0;
            hdr[1] = tfhc_pkg::MAGIC_1;
            hdr[2] = tfhc_pkg::MAGIC_2;
            hdr[3] = tfhc_pkg::MAGIC_3;
            hdr[4] = tfhc_pkg::HDR_VERSION;
            hdr[5] = tfhc_pkg::FRAME_TYPE;
            {hdr[7], hdr[6]}                     = tfhc_pkg::HDR_LENGTH;
            {hdr[11], hdr[10], hdr[9], hdr[8]}   = frame_seq;
            {hdr[15], hdr[14], hdr[13], hdr[12]} = stamp;
            {hdr[17], hdr[16]}                   = 16'(width_reg);
            {hdr[19], hdr[18]}                   = 16'(height_reg);
            {hdr[23], hdr[22], hdr[21], hdr[20]} = payload;
            {hdr[27], hdr[26], hdr[25], hdr[24]} = ~crc_acc;
            for (int i = 0; i < tfhc_pkg::HDR_BYTES; i++) begin
                beat.value  = hdr[i];
                beat.is_end = (i == tfhc_pkg::HDR_BYTES - 1);
                beat.offset = i;
                beats_due.push_back(beat);
            end
            frame_seq = frame_seq + 32'd1;
            crc_acc   = tfhc_pkg::CRC_INIT;
            frames_closed++;
        endfunction

        function void check_byte(logic [7:0] value, logic is_end);
            t_hdr_beat due;
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t: header beat 0x%02h arrived with no frame closed", $time, value);
                return;
            end
            due = beats_due.pop_front();
            bytes_checked++;
            if (value !== due.value) begin
                errors++;
                $display("%0t: header byte %0d: expected 0x%02h, got 0x%02h",
                         $time, due.offset, due.value, value);
            end
            if (is_end !== due.is_end) begin
                errors++;
                $display("%0t: tlast on header byte %0d: expected %0b, got %0b",
                         $time, due.offset, due.is_end, is_end);
            end
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    t_cfg_idx             i_cfg_idx     = '0;
    t_dim                 i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;  // pixel_word, frame_time_ms
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // header_byte
    logic                 m_axis_tlast;

    header_scoreboard sb = new();

    int src_idle_pct = 0;
    int rx_idle_pct  = 0;
    bit rx_hold_req  = 1'b0;
    int rx_hold_left = 0;
    int items_sent   = 0;
    int cfg_writes   = 0;
    int cycle_count  = 0;

    thermal_frame_header_crc32 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_pixel(s_axis_tdata[31:0], s_axis_tlast, s_axis_tdata[63:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_byte(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run stopped after %0d cycles, %0d header bytes still due",
                     $time, cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_pixel(input logic [31:0] word, input logic last,
                              input logic [31:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, word};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input t_dim data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic set_idle(input int src_pct, input int rx_pct);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        src_idle_pct = src_pct;
        rx_idle_pct  = rx_pct;
        @(negedge i_clk);
    endtask

    task automatic random_config();
        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, t_dim'($urandom_range(1023)));
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, t_dim'($urandom_range(1023)));
        write_cfg(t_cfg_idx'($urandom_range(3)), t_dim'($urandom_range(1023)));
    endtask

    task automatic random_frame(input int max_len);
        int          n;
        logic [31:0] word;
        n = $urandom_range(max_len, 1);
        for (int p = 0; p < n; p++) begin
            word = $urandom;
            if ($urandom_range(7) == 0) begin
                word = {32{word[0]}};
            end
            send_pixel(word, (p == n - 1), $urandom);
        end
    endtask

    task automatic random_frames(input int target);
        while (items_sent < target) begin
            random_frame(($urandom_range(9) == 0) ? 24 : 6);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset dimensions, all-zero and all-one words and timestamps.
        send_pixel(32'h0000_0000, 1'b0, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        send_pixel(32'hDEAD_BEEF, 1'b1, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        drain();

        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, 10'd1023);
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd1023);
        send_pixel(32'h8000_0000, 1'b0, 32'h0000_0001);
        send_pixel(32'h0000_0001, 1'b1, 32'h8000_0000);
        drain();

        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, 10'd1);
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd1);
        send_pixel(32'h1234_5678, 1'b1, 32'h0000_0001);
        drain();

        // Zero dimensions are taken as written and give a zero payload length.
        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, 10'd0);
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd5);
        send_pixel(32'hA5A5_5A5A, 1'b1, 32'h5A5A_A5A5);
        drain();
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd0);
        send_pixel(32'h0F0F_F0F0, 1'b1, 32'hF0F0_0F0F);
        drain();

        // Writes to unmapped indexes must leave both dimensions alone.
        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, 10'd10);
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd10);
        write_cfg(REG_UNMAPPED_2, 10'd1023);
        write_cfg(REG_UNMAPPED_3, 10'd0);
        send_pixel(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
        drain();

        // A dimension change between pixels of one frame lands in its header.
        send_pixel(32'h0102_0304, 1'b0, 32'h0000_0000);
        send_pixel(32'hFEDC_BA98, 1'b0, 32'h0000_0000);
        drain();
        write_cfg(tfhc_pkg::REG_FRAME_WIDTH, 10'd640);
        write_cfg(tfhc_pkg::REG_FRAME_HEIGHT, 10'd480);
        send_pixel(32'hCAFE_F00D, 1'b1, 32'h0001_0000);

        repeat (4) send_pixel($urandom, 1'b1, $urandom);
        drain();

        set_idle(26, 55);
        random_frames(items_sent + PHASE_ITEMS);
        drain();

        // Long output stall while single-beat frames keep arriving.
        set_idle(26, 55);
        @(posedge i_clk);
        rx_hold_req = 1'b1;
        @(negedge i_clk);
        repeat (8) send_pixel($urandom, 1'b1, $urandom);
        drain();

        random_config();
        set_idle(55, 26);
        random_frames(items_sent + PHASE_ITEMS);
        drain();

        random_config();
        set_idle(0, 0);
        random_frames(items_sent + PHASE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d pixel beats in %0d frames; %0d header bytes were checked.",
                 sb.pixels_seen, sb.frames_closed, sb.bytes_checked);
        $display("Made %0d register writes with zero, maximum and unmapped-index cases.",
                 cfg_writes);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
